// ===== hdl/cpmt_pkg.sv =====
// Shared types, codes and constants of the corner point merge table.
package cpmt_pkg;

  localparam int MAX_MARKS_DEF  = 64;
  localparam int COORD_BITS     = 11;
  localparam int SCORE_BITS     = 16;
  localparam int SLOT_BITS      = 6;
  localparam int COUNT_BITS     = 7;
  localparam int REQ_BITS       = 2;
  localparam int MD_BITS        = 8;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = COORD_BITS + 1;
  localparam int CMDQ_DEPTH     = 2;

  localparam int REGION_END_RST = 1 << COORD_BITS;
  localparam int MERGE_DIST_RST = 10;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_OFFER = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_START    = 3'd0,
    CFG_X_END      = 3'd1,
    CFG_Y_START    = 3'd2,
    CFG_Y_END      = 3'd3,
    CFG_MERGE_DIST = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_OFFER,
    CMD_READ,
    CMD_CLEAR,
    CMD_IGNORE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ACT_INSERTED = 3'd0,
    ACT_REPLACED = 3'd1,
    ACT_KEPT     = 3'd2,
    ACT_DROPPED  = 3'd3,
    ACT_OUTSIDE  = 3'd4,
    ACT_READ     = 3'd5,
    ACT_CLEARED  = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_SCAN,
    B_OUT
  } back_state_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic [SCORE_BITS-1:0]   score;
    logic [SLOT_BITS-1:0]    slot;
  } cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic [SCORE_BITS-1:0]   score;
  } mark_t;

  typedef struct packed {
    action_t                 action;
    logic [SLOT_BITS-1:0]    slot;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic                    valid;
    logic [COUNT_BITS-1:0]   count;
  } result_t;

endpackage

// ===== hdl/cpmt_front.sv =====
// Front part: configuration registers, item intake and request classification.
module cpmt_front
  import cpmt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic [REQ_BITS-1:0]       in_req_type,
  input  logic [COORD_BITS-1:0]     in_point_x,
  input  logic [COORD_BITS-1:0]     in_point_y,
  input  logic [SCORE_BITS-1:0]     in_point_score,
  input  logic [SLOT_BITS-1:0]      in_read_slot,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      q_full,
  output logic                      q_push,
  output cmd_t                      q_cmd,
  output logic [MD_BITS-1:0]        merge_dist
);

  logic [COORD_BITS-1:0] x_start_r;
  logic [COORD_BITS:0]   x_end_r;
  logic [COORD_BITS-1:0] y_start_r;
  logic [COORD_BITS:0]   y_end_r;
  logic [MD_BITS-1:0]    merge_dist_r;
  logic                  outside;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r    <= '0;
      x_end_r      <= (COORD_BITS+1)'(REGION_END_RST);
      y_start_r    <= '0;
      y_end_r      <= (COORD_BITS+1)'(REGION_END_RST);
      merge_dist_r <= MD_BITS'(MERGE_DIST_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_START:    x_start_r    <= cfg_data[COORD_BITS-1:0];
        CFG_X_END:      x_end_r      <= cfg_data[COORD_BITS:0];
        CFG_Y_START:    y_start_r    <= cfg_data[COORD_BITS-1:0];
        CFG_Y_END:      y_end_r      <= cfg_data[COORD_BITS:0];
        CFG_MERGE_DIST: merge_dist_r <= cfg_data[MD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Crossed or empty bounds make every point fall outside.
  assign outside = (in_point_x < x_start_r) || ({1'b0, in_point_x} >= x_end_r) ||
                   (in_point_y < y_start_r) || ({1'b0, in_point_y} >= y_end_r);

  always_comb begin
    q_cmd.x     = in_point_x;
    q_cmd.y     = in_point_y;
    q_cmd.score = in_point_score;
    q_cmd.slot  = in_read_slot;
    unique case (in_req_type)
      REQ_OFFER: q_cmd.kind = outside ? CMD_IGNORE : CMD_OFFER;
      REQ_READ:  q_cmd.kind = CMD_READ;
      REQ_CLEAR: q_cmd.kind = CMD_CLEAR;
      default:   q_cmd.kind = CMD_IGNORE;
    endcase
  end

  assign q_push     = in_push && !q_full;
  assign merge_dist = merge_dist_r;

endmodule

// ===== hdl/cpmt_cmd_fifo.sv =====
// Short command queue that decouples the front part from the back part.
module cpmt_cmd_fifo
  import cpmt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int NW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          buf_r [CMDQ_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (32'(cnt_r) == CMDQ_DEPTH);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = buf_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (32'(wp_r) == CMDQ_DEPTH - 1) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (32'(rp_r) == CMDQ_DEPTH - 1) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wp_r] <= din;
    end
  end

endmodule

// ===== hdl/cpmt_back.sv =====
// Back part: mark memory, slot scan sequencer and result register.
module cpmt_back
  import cpmt_pkg::*;
#(
  parameter int MAX_MARKS = MAX_MARKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  input  logic [MD_BITS-1:0] merge_dist,
  output logic               out_empty,
  input  logic               out_pop,
  output result_t            out_res
);

  localparam int IW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam int CW = $clog2(MAX_MARKS + 1);

  back_state_t     state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  result_t         res_r, res_nxt;
  result_t         out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  mark_t           mem [MAX_MARKS];
  mark_t           rd_data_r;
  mark_t           mem_wd;
  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  logic [IW-1:0]   rd_addr;

  logic [COORD_BITS-1:0] dx, dy;
  logic            hit, higher, last, has_room, read_hit, fill_zero, out_free;

  // While scanning, the next slot is fetched as the current one is compared.
  assign rd_addr = (state_r == B_SCAN) ? idx_r + 1'b1 : idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign dx = (cmd_r.x > rd_data_r.x) ? cmd_r.x - rd_data_r.x : rd_data_r.x - cmd_r.x;
  assign dy = (cmd_r.y > rd_data_r.y) ? cmd_r.y - rd_data_r.y : rd_data_r.y - cmd_r.y;
  assign hit = (dx < {{(COORD_BITS-MD_BITS){1'b0}}, merge_dist}) &&
               (dy < {{(COORD_BITS-MD_BITS){1'b0}}, merge_dist});
  assign higher    = cmd_r.score > rd_data_r.score;
  assign last      = (32'(idx_r) + 32'd1) >= 32'(fill_r);
  assign has_room  = 32'(fill_r) < MAX_MARKS;
  assign read_hit  = 32'(q_cmd.slot) < 32'(fill_r);
  assign fill_zero = (fill_r == '0);
  assign out_free  = !out_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.kind)
            CMD_OFFER: state_nxt = fill_zero ? B_OUT : B_FETCH;
            CMD_READ:  state_nxt = read_hit ? B_FETCH : B_OUT;
            default:   state_nxt = B_OUT;
          endcase
        end
      end
      B_FETCH: state_nxt = B_SCAN;
      B_SCAN: begin
        if (cmd_r.kind == CMD_READ || hit || last) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    fill_nxt      = fill_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd.x      = cmd_r.x;
    mem_wd.y      = cmd_r.y;
    mem_wd.score  = cmd_r.score;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          cmd_nxt       = q_cmd;
          res_nxt       = '0;
          res_nxt.count = COUNT_BITS'(fill_r);
          case (q_cmd.kind)
            CMD_OFFER: begin
              idx_nxt = '0;
              res_nxt.action = ACT_INSERTED;
              // An empty table takes the point in slot zero without a scan.
              if (fill_zero) begin
                mem_we        = 1'b1;
                mem_wa        = '0;
                mem_wd.x      = q_cmd.x;
                mem_wd.y      = q_cmd.y;
                mem_wd.score  = q_cmd.score;
                fill_nxt      = CW'(1);
                res_nxt.x     = q_cmd.x;
                res_nxt.y     = q_cmd.y;
                res_nxt.valid = 1'b1;
                res_nxt.count = COUNT_BITS'(1);
              end
            end
            CMD_READ: begin
              idx_nxt        = IW'(q_cmd.slot);
              res_nxt.action = ACT_READ;
              res_nxt.slot   = q_cmd.slot;
            end
            CMD_CLEAR: begin
              fill_nxt       = '0;
              res_nxt.action = ACT_CLEARED;
              res_nxt.count  = '0;
            end
            default: begin
              res_nxt.action = ACT_OUTSIDE;
            end
          endcase
        end
      end
      B_FETCH: ;
      B_SCAN: begin
        if (cmd_r.kind == CMD_READ) begin
          res_nxt.x     = rd_data_r.x;
          res_nxt.y     = rd_data_r.y;
          res_nxt.valid = 1'b1;
        end else if (hit) begin
          res_nxt.slot  = SLOT_BITS'(idx_r);
          res_nxt.valid = 1'b1;
          if (higher) begin
            mem_we         = 1'b1;
            mem_wa         = idx_r;
            res_nxt.action = ACT_REPLACED;
            res_nxt.x      = cmd_r.x;
            res_nxt.y      = cmd_r.y;
          end else begin
            res_nxt.action = ACT_KEPT;
            res_nxt.x      = rd_data_r.x;
            res_nxt.y      = rd_data_r.y;
          end
        end else if (!last) begin
          idx_nxt = idx_r + 1'b1;
        end else if (has_room) begin
          mem_we         = 1'b1;
          mem_wa         = IW'(fill_r);
          fill_nxt       = fill_r + 1'b1;
          res_nxt.action = ACT_INSERTED;
          res_nxt.slot   = SLOT_BITS'(fill_r);
          res_nxt.x      = cmd_r.x;
          res_nxt.y      = cmd_r.y;
          res_nxt.valid  = 1'b1;
          res_nxt.count  = COUNT_BITS'(fill_r + 1'b1);
        end else begin
          res_nxt.action = ACT_DROPPED;
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_res   = out_r;

endmodule

// ===== hdl/corner_point_merge_table.sv =====
// Top level of the corner point merge table.
//
// Items enter through a queue-like port: an item is taken at a clock edge with
// in_push high and in_full low. A front part classifies it (offer, read, clear,
// or ignored when outside the region or of an unknown type) and places it in a
// two-entry command queue. A back part carries each item out against the mark
// memory and leaves one result in an output register, shown while out_empty is
// low and taken at an edge with out_pop high.
// A clear, an ignored item, a read of an empty slot or a point offered to an
// empty table needs no scan; a read of a held slot fetches only that slot. Any
// other offered point scans the held marks in slot order, one mark a cycle
// through the single read port of the mark memory, up to the first mark closer
// than the merge distance on both axes or the last held mark. Items are carried
// out one at a time. If the receiver stalls, the finished result waits in the
// output register while the back part works on the next item and the command
// queue keeps taking items until it is full. Synchronous reset empties the
// table and both queues and loads the region and merge distance registers with
// their defaults. Configuration is written through cfg_we, cfg_index and
// cfg_data by the user only while idle; the block itself does not enforce it.
module corner_point_merge_table
  import cpmt_pkg::*;
#(
  parameter int MAX_MARKS = MAX_MARKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [REQ_BITS-1:0]       in_req_type,
  input  logic [COORD_BITS-1:0]     in_point_x,
  input  logic [COORD_BITS-1:0]     in_point_y,
  input  logic [SCORE_BITS-1:0]     in_point_score,
  input  logic [SLOT_BITS-1:0]      in_read_slot,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [2:0]                out_action,
  output logic [SLOT_BITS-1:0]      out_slot_index,
  output logic [COORD_BITS-1:0]     out_entry_x,
  output logic [COORD_BITS-1:0]     out_entry_y,
  output logic                      out_entry_valid,
  output logic [COUNT_BITS-1:0]     out_mark_count,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic               q_push, q_full, q_pop, q_empty;
  cmd_t               q_in, q_out;
  logic [MD_BITS-1:0] merge_dist;
  result_t            res;

  cpmt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_req_type    (in_req_type),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_score (in_point_score),
    .in_read_slot   (in_read_slot),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_in),
    .merge_dist     (merge_dist)
  );

  cpmt_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  cpmt_back #(
    .MAX_MARKS (MAX_MARKS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (q_out),
    .q_pop      (q_pop),
    .merge_dist (merge_dist),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_res    (res)
  );

  assign in_full         = q_full;
  assign out_action      = res.action;
  assign out_slot_index  = res.slot;
  assign out_entry_x     = res.x;
  assign out_entry_y     = res.y;
  assign out_entry_valid = res.valid;
  assign out_mark_count  = res.count;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the corner point merge table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cpmt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = MAX_MARKS_DEF + 10;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic [REQ_BITS-1:0]      in_req_type = '0;
  logic [COORD_BITS-1:0]    in_point_x = '0;
  logic [COORD_BITS-1:0]    in_point_y = '0;
  logic [SCORE_BITS-1:0]    in_point_score = '0;
  logic [SLOT_BITS-1:0]     in_read_slot = '0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic [2:0]               out_action;
  logic [SLOT_BITS-1:0]     out_slot_index;
  logic [COORD_BITS-1:0]    out_entry_x;
  logic [COORD_BITS-1:0]    out_entry_y;
  logic                     out_entry_valid;
  logic [COUNT_BITS-1:0]    out_mark_count;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Mirror of the block's registers and mark table.
  logic [COORD_BITS-1:0]    x_start_r = '0;
  logic [COORD_BITS:0]      x_end_r = (COORD_BITS+1)'(REGION_END_RST);
  logic [COORD_BITS-1:0]    y_start_r = '0;
  logic [COORD_BITS:0]      y_end_r = (COORD_BITS+1)'(REGION_END_RST);
  logic [MD_BITS-1:0]       merge_dist_r = MD_BITS'(MERGE_DIST_RST);
  logic [COORD_BITS-1:0]    held_x [MAX_MARKS_DEF];
  logic [COORD_BITS-1:0]    held_y [MAX_MARKS_DEF];
  logic [SCORE_BITS-1:0]    held_score [MAX_MARKS_DEF];
  int                       held_count = 0;

  result_t merge_outcomes [$];
  int      fail_count = 0;
  int      quiet_cycles = 0;
  int      burst_left = 0;
  bit      gaps_on = 1'b0;
  int      pop_pct = 100;
  int      pop_cycle = 0;
  int      centers_x [$];
  int      centers_y [$];

  corner_point_merge_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_score (in_point_score),
    .in_read_slot   (in_read_slot),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_action     (out_action),
    .out_slot_index (out_slot_index),
    .out_entry_x    (out_entry_x),
    .out_entry_y    (out_entry_y),
    .out_entry_valid(out_entry_valid),
    .out_mark_count (out_mark_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one item to the mirrored table and returns the result it must produce.
  function automatic result_t merge_outcome(req_t req, logic [COORD_BITS-1:0] px,
                                            logic [COORD_BITS-1:0] py,
                                            logic [SCORE_BITS-1:0] ps,
                                            logic [SLOT_BITS-1:0] rs);
    result_t r;
    int      i;
    int      dx;
    int      dy;
    bit      matched;
    r = '0;
    r.action = ACT_OUTSIDE;
    matched = 1'b0;
    case (req)
      REQ_READ: begin
        r.action = ACT_READ;
        r.slot = rs;
        if (rs < held_count) begin
          r.x = held_x[rs];
          r.y = held_y[rs];
          r.valid = 1'b1;
        end
      end
      REQ_CLEAR: begin
        held_count = 0;
        r.action = ACT_CLEARED;
      end
      REQ_OFFER: begin
        if (px >= x_start_r && {1'b0, px} < x_end_r &&
            py >= y_start_r && {1'b0, py} < y_end_r) begin
          for (i = 0; i < held_count && !matched; i++) begin
            dx = (px > held_x[i]) ? int'(px) - int'(held_x[i]) : int'(held_x[i]) - int'(px);
            dy = (py > held_y[i]) ? int'(py) - int'(held_y[i]) : int'(held_y[i]) - int'(py);
            if (dx < merge_dist_r && dy < merge_dist_r) begin
              matched = 1'b1;
              r.slot = SLOT_BITS'(i);
              r.valid = 1'b1;
              if (ps > held_score[i]) begin
                held_x[i] = px;
                held_y[i] = py;
                held_score[i] = ps;
                r.action = ACT_REPLACED;
              end else begin
                r.action = ACT_KEPT;
              end
              r.x = held_x[i];
              r.y = held_y[i];
            end
          end
          if (!matched) begin
            if (held_count < MAX_MARKS_DEF) begin
              held_x[held_count] = px;
              held_y[held_count] = py;
              held_score[held_count] = ps;
              r.action = ACT_INSERTED;
              r.slot = SLOT_BITS'(held_count);
              r.x = px;
              r.y = py;
              r.valid = 1'b1;
              held_count++;
            end else begin
              r.action = ACT_DROPPED;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_BITS'(held_count);
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > 2047) return 11'd2047;
    return COORD_BITS'(v);
  endfunction

  function automatic void field_check(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Leaves in_push high so that back-to-back items need no second assignment.
  task automatic send_item(req_t req, logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                           logic [SCORE_BITS-1:0] ps, logic [SLOT_BITS-1:0] rs);
    in_push <= 1'b1;
    in_req_type <= req;
    in_point_x <= px;
    in_point_y <= py;
    in_point_score <= ps;
    in_read_slot <= rs;
    do @(posedge clk); while (in_full !== 1'b0);
    merge_outcomes.push_back(merge_outcome(req, px, py, ps, rs));
  endtask

  task automatic pace();
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (merge_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(int unsigned xs, int unsigned xe, int unsigned ys,
                              int unsigned ye, int unsigned md);
    int unsigned vals [5];
    cfg_idx_t    regs [5];
    int          i;
    vals = '{xs, xe, ys, ye, md};
    regs = '{CFG_X_START, CFG_X_END, CFG_Y_START, CFG_Y_END, CFG_MERGE_DIST};
    wait_drained();
    for (i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= CFG_DATA_BITS'(vals[i]);
      @(posedge clk);
      case (regs[i])
        CFG_X_START:    x_start_r = COORD_BITS'(vals[i]);
        CFG_X_END:      x_end_r = (COORD_BITS+1)'(vals[i]);
        CFG_Y_START:    y_start_r = COORD_BITS'(vals[i]);
        CFG_Y_END:      y_end_r = (COORD_BITS+1)'(vals[i]);
        CFG_MERGE_DIST: merge_dist_r = MD_BITS'(vals[i]);
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Runs straight after reset, so the register defaults are in effect.
  task automatic test_defaults();
    gaps_on = 1'b0;
    send_item(REQ_READ, 0, 0, 0, 0);
    send_item(REQ_READ, 0, 0, 0, 63);
    send_item(REQ_OFFER, 0, 0, 16'h0000, 0);
    send_item(REQ_OFFER, 2047, 2047, 16'hFFFF, 63);
    send_item(REQ_OFFER, 5, 5, 16'h0000, 0);
    send_item(REQ_OFFER, 9, 9, 16'h0001, 0);
    send_item(REQ_OFFER, 19, 9, 16'h0100, 0);
    send_item(REQ_OFFER, 2040, 2038, 16'h0064, 0);
    send_item(REQ_READ, 0, 0, 0, 0);
    send_item(REQ_READ, 0, 0, 0, 2);
    send_item(REQ_READ, 0, 0, 0, 3);
    send_item(REQ_RSVD, 2047, 2047, 16'hFFFF, 63);
    send_item(REQ_CLEAR, 1234, 567, 16'h5A5A, 21);
    send_item(REQ_READ, 0, 0, 0, 0);
    send_item(REQ_OFFER, 1024, 1024, 16'h8080, 42);
    wait_drained();
  endtask

  task automatic test_region();
    gaps_on = 1'b0;
    program_regs(100, 200, 300, 400, 10);
    send_item(REQ_OFFER, 100, 300, 16'h0200, 0);
    send_item(REQ_OFFER, 199, 399, 16'h0200, 0);
    send_item(REQ_OFFER, 200, 350, 16'h0200, 0);
    send_item(REQ_OFFER, 99, 350, 16'h0200, 0);
    send_item(REQ_OFFER, 150, 299, 16'h0200, 0);
    send_item(REQ_OFFER, 150, 400, 16'h0200, 0);
    program_regs(2047, 2048, 2047, 2048, 10);
    send_item(REQ_OFFER, 2047, 2047, 16'h0001, 0);
    send_item(REQ_OFFER, 2046, 2047, 16'h0001, 0);
    // Start past end on one axis: nothing can be accepted.
    program_regs(500, 400, 0, 2048, 10);
    send_item(REQ_OFFER, 450, 1000, 16'h0300, 0);
    send_item(REQ_OFFER, 500, 1000, 16'h0300, 0);
    program_regs(0, 0, 0, 0, 10);
    send_item(REQ_OFFER, 0, 0, 16'h0300, 0);
    program_regs(0, 2048, 0, 2048, 10);
  endtask

  task automatic test_merge_distance();
    gaps_on = 1'b0;
    program_regs(0, 2048, 0, 2048, 0);
    send_item(REQ_CLEAR, 0, 0, 0, 0);
    send_item(REQ_OFFER, 10, 10, 16'h0005, 0);
    send_item(REQ_OFFER, 10, 10, 16'h0009, 0);
    program_regs(0, 2048, 0, 2048, 255);
    send_item(REQ_OFFER, 264, 264, 16'h0007, 0);
    send_item(REQ_OFFER, 265, 10, 16'h0007, 0);
    program_regs(0, 2048, 0, 2048, 1);
    send_item(REQ_OFFER, 264, 264, 16'h0008, 0);
    send_item(REQ_OFFER, 265, 264, 16'h0008, 0);
    send_item(REQ_CLEAR, 0, 0, 0, 0);
  endtask

  // Fills every slot so that drops and full-length scans are reached.
  task automatic test_table_full();
    int i;
    program_regs(0, 2048, 0, 2048, 10);
    gaps_on = 1'b1;
    send_item(REQ_CLEAR, 0, 0, 0, 0);
    for (i = 0; i < MAX_MARKS_DEF; i++) begin
      send_item(REQ_OFFER, COORD_BITS'((i % 8) * 256 + 3), COORD_BITS'((i / 8) * 256 + 5),
                SCORE_BITS'($urandom_range(0, 65534)), SLOT_BITS'($urandom_range(0, 63)));
      pace();
    end
    send_item(REQ_OFFER, 2047, 2047, 16'hFFFF, 0);
    send_item(REQ_OFFER, 0, 2047, 16'h1234, 0);
    send_item(REQ_OFFER, 1799, 1793, 16'hFFFF, 0);
    send_item(REQ_OFFER, 1791, 1801, 16'h0000, 0);
    send_item(REQ_READ, 0, 0, 0, 63);
    send_item(REQ_READ, 0, 0, 0, 0);
    send_item(REQ_CLEAR, 0, 0, 0, 0);
    wait_drained();
  endtask

  task automatic offer_random();
    int pick;
    int c;
    int spread;
    int top;
    pick = $urandom_range(0, 99);
    spread = int'(merge_dist_r) + 2;
    if (pick < 70) begin
      c = $urandom_range(0, centers_x.size() - 1);
      send_item(REQ_OFFER,
                clamp_coord(centers_x[c] + int'($urandom_range(0, 2 * spread)) - spread),
                clamp_coord(centers_y[c] + int'($urandom_range(0, 2 * spread)) - spread),
                ($urandom_range(0, 7) == 0) ? 16'hFFFF : SCORE_BITS'($urandom_range(0, 65535)),
                SLOT_BITS'($urandom_range(0, 63)));
    end else if (pick < 82) begin
      send_item(REQ_OFFER, COORD_BITS'($urandom_range(0, 2047)),
                COORD_BITS'($urandom_range(0, 2047)),
                SCORE_BITS'($urandom_range(0, 65535)), SLOT_BITS'($urandom_range(0, 63)));
    end else if (pick < 94) begin
      top = (held_count > 63) ? 63 : held_count;
      send_item(REQ_READ, COORD_BITS'($urandom_range(0, 2047)),
                COORD_BITS'($urandom_range(0, 2047)),
                SCORE_BITS'($urandom_range(0, 65535)),
                SLOT_BITS'($urandom_range(0, 1) ? $urandom_range(0, 63)
                                                : $urandom_range(0, top)));
    end else if (pick < 97) begin
      send_item(REQ_CLEAR, COORD_BITS'($urandom_range(0, 2047)),
                COORD_BITS'($urandom_range(0, 2047)),
                SCORE_BITS'($urandom_range(0, 65535)), SLOT_BITS'($urandom_range(0, 63)));
    end else begin
      send_item(REQ_RSVD, COORD_BITS'($urandom_range(0, 2047)),
                COORD_BITS'($urandom_range(0, 2047)),
                SCORE_BITS'($urandom_range(0, 65535)), SLOT_BITS'($urandom_range(0, 63)));
    end
  endtask

  task automatic test_random_phases();
    int phase;
    int n;
    int lo;
    int hi;
    int xs;
    int ys;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_regs(0, 2048, 0, 2048, 10);
        1: begin
          xs = $urandom_range(0, 1500);
          ys = $urandom_range(0, 1500);
          program_regs(xs, $urandom_range(xs + 1, 2048), ys, $urandom_range(ys + 1, 2048),
                       $urandom_range(1, 255));
        end
        2: program_regs(0, 2048, 0, 2048, 1);
        3: program_regs(0, 2048, 0, 2048, 255);
        default: begin
          xs = $urandom_range(0, 1000);
          ys = $urandom_range(0, 1000);
          program_regs(xs, xs + $urandom_range(200, 1000), ys, ys + $urandom_range(200, 1000),
                       $urandom_range(1, 40));
        end
      endcase
      centers_x.delete();
      centers_y.delete();
      repeat ($urandom_range(4, 40)) begin
        lo = int'(x_start_r);
        hi = (x_end_r > x_start_r) ? int'(x_end_r) - 1 : lo;
        centers_x.push_back($urandom_range(lo, hi));
        lo = int'(y_start_r);
        hi = (y_end_r > y_start_r) ? int'(y_end_r) - 1 : lo;
        centers_y.push_back($urandom_range(lo, hi));
      end
      // One phase runs with the sender never idling.
      gaps_on = (phase != 2);
      burst_left = 0;
      for (n = 0; n < 100; n++) begin
        offer_random();
        pace();
      end
    end
  endtask

  // Receiver: checks each result; its stall rate is redrawn at random, with full-rate stretches.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (merge_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual action %0d", $time, out_action);
        end else begin
          field_check("action", 16'(merge_outcomes[0].action), 16'(out_action));
          field_check("slot_index", 16'(merge_outcomes[0].slot), 16'(out_slot_index));
          field_check("entry_x", 16'(merge_outcomes[0].x), 16'(out_entry_x));
          field_check("entry_y", 16'(merge_outcomes[0].y), 16'(out_entry_y));
          field_check("entry_valid", 16'(merge_outcomes[0].valid), 16'(out_entry_valid));
          field_check("mark_count", 16'(merge_outcomes[0].count), 16'(out_mark_count));
          void'(merge_outcomes.pop_front());
        end
      end
      pop_cycle++;
      if (pop_cycle % 300 == 0) begin
        case ($urandom_range(0, 3))
          0: pop_pct = 100;
          1: pop_pct = 60;
          2: pop_pct = 25;
          default: pop_pct = 8;
        endcase
      end
    end
    out_pop <= ($urandom_range(0, 99) < pop_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL corner_point_merge_table");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_region();
    test_merge_distance();
    test_table_full();
    test_random_phases();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS corner_point_merge_table");
    end else begin
      $display("FAIL corner_point_merge_table");
    end
    $finish;
  end

endmodule
